// ===== rtl/u8enc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8enc_pkg
// Shared types and constants for the UTF-8 encoder with per-string byte limit.
// ----------------------------------------------------------------------------
package u8enc_pkg;

    localparam int unsigned CP_W    = 32;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned MAX_B   = 4;

    // Upper bounds of the 1..4 byte ranges
    localparam logic [CP_W-1:0] MAX_1B = 32'h0000_007F;
    localparam logic [CP_W-1:0] MAX_2B = 32'h0000_07FF;
    localparam logic [CP_W-1:0] MAX_3B = 32'h0000_FFFF;
    localparam logic [CP_W-1:0] MAX_4B = 32'h0010_FFFF;

    // Lead and continuation markers
    localparam logic [BYTE_W-1:0] LEAD_2B = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_3B = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4B = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_B  = 8'h80;
    localparam logic [5:0]        CONT_MASK = 6'h3F;

    localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam logic CFG_LIMIT_ENABLE = 1'b0;
    localparam logic CFG_BYTE_LIMIT   = 1'b1;

    typedef logic [MAX_B-1:0][BYTE_W-1:0] t_bytes;

    // Encode stage result: bytes to send plus next string state
    typedef struct packed {
        logic              emit;      // one or more bytes to send
        logic [1:0]        last_idx;  // index of final byte
        t_bytes            bytes;     // lead byte at index 0
        logic [CNT_W-1:0]  next_count;
        logic              next_trunc;
    } t_enc_result;

endpackage

// ===== rtl/u8enc_encode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8enc_encode
// Length classification, byte formation and byte-limit check for one request.
// ----------------------------------------------------------------------------
module u8enc_encode (
    input  logic [u8enc_pkg::CP_W-1:0]    i_code_point,
    input  logic                          i_string_start,
    input  logic                          i_limit_enable,
    input  logic [u8enc_pkg::LIMIT_W-1:0] i_byte_limit,
    input  logic [u8enc_pkg::CNT_W-1:0]   i_count,
    input  logic                          i_trunc,
    output u8enc_pkg::t_enc_result        o_res
);

    logic [2:0]                        len;
    logic [u8enc_pkg::CNT_W-1:0]       eff_count;
    logic                              eff_trunc;
    logic [u8enc_pkg::CNT_W:0]         sum;
    logic                              over;
    logic [5:0]                        c0;
    logic [5:0]                        c1;
    logic [5:0]                        c2;

    assign c0 = i_code_point[5:0]   & u8enc_pkg::CONT_MASK;
    assign c1 = i_code_point[11:6]  & u8enc_pkg::CONT_MASK;
    assign c2 = i_code_point[17:12] & u8enc_pkg::CONT_MASK;

    always_comb begin
        if (i_code_point <= u8enc_pkg::MAX_1B) begin
            len = 3'd1;
        end else if (i_code_point <= u8enc_pkg::MAX_2B) begin
            len = 3'd2;
        end else if (i_code_point <= u8enc_pkg::MAX_3B) begin
            len = 3'd3;
        end else if (i_code_point <= u8enc_pkg::MAX_4B) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
    end

    // A string start clears count and stop mark before this character
    assign eff_count = i_string_start ? '0 : i_count;
    assign eff_trunc = i_string_start ? 1'b0 : i_trunc;
    assign sum  = {1'b0, eff_count} + {{(u8enc_pkg::CNT_W-2){1'b0}}, len};
    assign over = i_limit_enable &&
                  (sum > {{(u8enc_pkg::CNT_W+1-u8enc_pkg::LIMIT_W){1'b0}}, i_byte_limit});

    always_comb begin
        o_res            = '0;
        o_res.next_count = eff_count;
        o_res.next_trunc = eff_trunc;
        if (eff_trunc) begin
            o_res.next_trunc = 1'b1;
        end else if (over) begin
            o_res.next_trunc = 1'b1;
        end else if (len != 3'd0) begin
            o_res.emit       = 1'b1;
            o_res.last_idx   = 2'(len - 3'd1);
            o_res.next_count = sum[u8enc_pkg::CNT_W] ? u8enc_pkg::COUNT_MAX
                                                     : sum[u8enc_pkg::CNT_W-1:0];
            case (len)
                3'd1: begin
                    o_res.bytes[0] = i_code_point[7:0];
                end
                3'd2: begin
                    o_res.bytes[0] = u8enc_pkg::LEAD_2B | {3'b000, i_code_point[10:6]};
                    o_res.bytes[1] = u8enc_pkg::CONT_B | {2'b00, c0};
                end
                3'd3: begin
                    o_res.bytes[0] = u8enc_pkg::LEAD_3B | {4'h0, i_code_point[15:12]};
                    o_res.bytes[1] = u8enc_pkg::CONT_B | {2'b00, c1};
                    o_res.bytes[2] = u8enc_pkg::CONT_B | {2'b00, c0};
                end
                default: begin
                    o_res.bytes[0] = u8enc_pkg::LEAD_4B | {5'h00, i_code_point[20:18]};
                    o_res.bytes[1] = u8enc_pkg::CONT_B | {2'b00, c2};
                    o_res.bytes[2] = u8enc_pkg::CONT_B | {2'b00, c1};
                    o_res.bytes[3] = u8enc_pkg::CONT_B | {2'b00, c0};
                end
            endcase
        end
    end

endmodule

// ===== rtl/u8enc_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8enc_serializer
// Result register holding one character's bytes, sent one byte at a time.
// ----------------------------------------------------------------------------
module u8enc_serializer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [1:0]                    i_last_idx,
    input  u8enc_pkg::t_bytes             i_bytes,
    output logic                          o_free,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [u8enc_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                          o_char_last
);

    logic              r_valid;
    logic [1:0]        r_idx;
    logic [1:0]        r_last;
    u8enc_pkg::t_bytes r_bytes;
    logic              take;
    logic              at_last;

    assign at_last     = (r_idx == r_last);
    assign take        = r_valid && !i_stall;
    assign o_free      = !r_valid || (take && at_last);
    assign o_valid     = r_valid;
    assign o_out_byte  = r_bytes[r_idx];
    assign o_char_last = at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_bytes;
            r_last  <= i_last_idx;
        end
    end

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("load into busy result register");
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= r_last))
        else $error("byte index past final byte");
    a_new_char_at_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_valid && r_idx == 2'd0))
        else $error("new character not starting at lead byte");
`endif

endmodule

// ===== rtl/utf8_encoder_with_byte_limit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_encoder_with_byte_limit
// UTF-8 encoder with a running per-string byte count and optional byte limit.
// ----------------------------------------------------------------------------
// Each accepted request carries one code point and a string-start flag. The
// code point is encoded to 1..4 UTF-8 bytes (lead byte first), which leave one
// byte per cycle on the output channel while i_stall is low, with o_char_last
// on the final byte. Values above 0x10FFFF produce no bytes. With limit_enable
// set, a character that would push the string's byte count past byte_limit is
// dropped, and so is every later character until the next string start. A
// request is registered in the input register on accept, encoded and checked
// against the limit there, and its bytes are loaded into the result register
// once that is free. An item that yields bytes holds the result register until
// its final byte is taken; items that yield no bytes pass at one per cycle while
// the result register is free. Configuration writes take effect for the next
// request and must be made while the block is idle.
// ----------------------------------------------------------------------------
module utf8_encoder_with_byte_limit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [u8enc_pkg::LIMIT_W-1:0] i_cfg_data,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [u8enc_pkg::CP_W-1:0]    i_code_point,
    input  logic                          i_string_start,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [u8enc_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                          o_char_last
);

    // Configuration registers
    logic                          r_limit_enable;
    logic [u8enc_pkg::LIMIT_W-1:0] r_byte_limit;

    // Input register
    logic                          r_in_valid;
    logic [u8enc_pkg::CP_W-1:0]    r_code_point;
    logic                          r_string_start;

    // String state
    logic [u8enc_pkg::CNT_W-1:0]   r_count;
    logic                          r_trunc;

    u8enc_pkg::t_enc_result        enc;
    logic                          res_free;
    logic                          adv;
    logic                          in_take;

    // Input stage moves on once the result register can take its bytes;
    // a request without bytes also waits, keeping requests in order.
    assign adv     = r_in_valid && res_free;
    assign o_stall = r_in_valid && !res_free;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_enable <= 1'b0;
            r_byte_limit   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                u8enc_pkg::CFG_LIMIT_ENABLE: r_limit_enable <= i_cfg_data[0];
                u8enc_pkg::CFG_BYTE_LIMIT:   r_byte_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_code_point   <= i_code_point;
            r_string_start <= i_string_start;
        end
    end

    // Count and stop mark update as each request leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_trunc <= 1'b0;
        end else if (adv) begin
            r_count <= enc.next_count;
            r_trunc <= enc.next_trunc;
        end
    end

    u8enc_encode u_encode (
        .i_code_point   (r_code_point),
        .i_string_start (r_string_start),
        .i_limit_enable (r_limit_enable),
        .i_byte_limit   (r_byte_limit),
        .i_count        (r_count),
        .i_trunc        (r_trunc),
        .o_res          (enc)
    );

    u8enc_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (adv && enc.emit),
        .i_last_idx  (enc.last_idx),
        .i_bytes     (enc.bytes),
        .o_free      (res_free),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_char_last (o_char_last)
    );

`ifndef ASSERT_OFF
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("input stalled with empty input register");
    a_start_count_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_string_start) |=> (r_count <= 32'd4))
        else $error("count not restarted on string start");
    a_trunc_via_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_trunc) |-> $past(adv))
        else $error("stop mark set without a request");
    a_trunc_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_trunc && !r_string_start) |-> !enc.emit)
        else $error("bytes emitted after stop mark");
`endif

endmodule
